### rtl/inductor_normalize_diff_ratio_defines.svh
// assertion macros for the inductor sensor front end
// no dependencies
`ifndef INDUCTOR_NORMALIZE_DIFF_RATIO_DEFINES_SVH
`define INDUCTOR_NORMALIZE_DIFF_RATIO_DEFINES_SVH
`define INR_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("inr check failed");
`define INR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("inr check failed");
`endif

### rtl/inr_pkg.sv
// types and constants for the inductor sensor front end
// no dependencies
package inr_pkg;
   localparam int unsigned SampleW = 12;
   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0, ACT_CAL = 2'd1, ACT_FINISH = 2'd2, ACT_MEASURE = 2'd3
   } action_type;
   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_RANGE = 2'd1, ST_SUM = 2'd2
   } status_type;
   localparam logic CSR_OUTER_GAIN = 1'b0;
   localparam logic CSR_INNER_GAIN = 1'b1;
   typedef enum logic [2:0] {
      S_IDLE, S_DIV_LVL, S_DIV_RATIO, S_STEER, S_DONE
   } state_type;
   typedef struct packed {
      logic [1:0] action;
      logic [SampleW-1:0] sample_left_outer;
      logic [SampleW-1:0] sample_left_inner;
      logic [SampleW-1:0] sample_right_inner;
      logic [SampleW-1:0] sample_right_outer;
   } req_type;
   typedef struct packed {
      logic signed [19:0] level_left_outer;
      logic signed [19:0] level_left_inner;
      logic signed [19:0] level_right_inner;
      logic signed [19:0] level_right_outer;
      logic signed [23:0] outer_ratio;
      logic signed [23:0] inner_ratio;
      logic signed [23:0] steer_error;
      logic [1:0] status;
   } rsp_type;
   localparam logic [12:0] MaxInit = 13'd1000;
   localparam logic [12:0] MinInit = 13'd5000;
   localparam logic [15:0] SpanR0 = 16'd1504;
   localparam logic [15:0] SpanR1 = 16'd1158;
   localparam logic [15:0] SpanR3 = 16'd2014;
endpackage

### rtl/inductor_normalize_diff_ratio.sv
// inductor sensor front end top level: trackers, bit-serial divider, steering
// depends on inr_pkg
//
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  inr_pkg::req_type
// rsp      out  rsp_valid/rsp_stall  inr_pkg::rsp_type
// csr      in   csr_valid/csr_ready  csr_index, csr_wdata
//
// clear, calibrate and finish go straight to the done state, which raises the result
// once the output is free; measure first runs four level divisions, two ratio
// divisions and the steering sum, and a bad span or a skipped pair skips its division
// one restoring divider, one quotient bit per cycle, serves all six divisions
// reset is synchronous and restores trackers, spans and gains
// the next item is taken in the cycle after a result is raised, a stalled result only
// holds the block in its last state
module inductor_normalize_diff_ratio (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  inr_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output inr_pkg::rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic csr_index,
   input  logic [15:0] csr_wdata
);
   import inr_pkg::*;

   state_type state_ff, state_in;
   req_type item_ff;
   rsp_type res_ff;
   logic [12:0] tmax_ff [4];
   logic [12:0] tmin_ff [4];
   logic [12:0] floor_ff [4];
   logic signed [15:0] span_ff [4];
   logic signed [15:0] ogain_ff, igain_ff;
   logic signed [19:0] lvl_ff [4];
   logic signed [23:0] ro_ff, ri_ff;
   logic oo_ff, io_ff, rbad_ff, sbad_ff;
   logic [1:0] ch_ff;
   logic sel_ff;
   logic [5:0] cnt_ff;
   logic [41:0] quo_ff;
   logic [21:0] rem_ff;
   logic [21:0] dvs_ff;
   logic neg_ff;
   logic signed [41:0] acc_ff;
   logic rsp_valid_ff;

   logic [SampleW-1:0] req_smp [4];
   logic [22:0] trial;
   logic [5:0] nbits;
   logic [41:0] dividend_abs;
   logic [21:0] divisor_abs;
   logic negate;
   logic skip;
   logic pair_ok;
   logic rsp_free;
   logic signed [21:0] diff;
   logic signed [22:0] psum, pdif;
   logic [41:0] qnext;
   logic [41:0] qsigned;
   logic signed [41:0] prod;
   logic signed [41:0] accsum;
   logic signed [33:0] shifted;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = res_ff;
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign req_smp[0] = req_data.sample_left_outer;
   assign req_smp[1] = req_data.sample_left_inner;
   assign req_smp[2] = req_data.sample_right_inner;
   assign req_smp[3] = req_data.sample_right_outer;
   assign trial = {rem_ff, quo_ff[41]} - {1'b0, dvs_ff};
   assign qnext = {quo_ff[40:0], ~trial[22]};
   assign qsigned = neg_ff ? (~qnext + 42'd1) : qnext;
   assign prod = sel_ff
      ? ($signed({{26{igain_ff[15]}}, igain_ff}) * $signed({{18{ri_ff[23]}}, ri_ff}))
      : ($signed({{26{ogain_ff[15]}}, ogain_ff}) * $signed({{18{ro_ff[23]}}, ro_ff}));
   assign accsum = acc_ff + prod;
   assign shifted = acc_ff[41:8];

   function automatic logic signed [19:0] sat20(input logic [41:0] v);
      if (!v[41] && v[41:19] != '0) return 20'sh7FFFF;
      if (v[41] && v[41:19] != '1) return -20'sh80000;
      return v[19:0];
   endfunction
   function automatic logic signed [23:0] sat24(input logic [41:0] v);
      if (!v[41] && v[41:23] != '0) return 24'sh7FFFFF;
      if (v[41] && v[41:23] != '1) return -24'sh800000;
      return v[23:0];
   endfunction

   always_comb begin
      logic [SampleW-1:0] s;
      s = '0;
      case (ch_ff)
         2'd0: s = item_ff.sample_left_outer;
         2'd1: s = item_ff.sample_left_inner;
         2'd2: s = item_ff.sample_right_inner;
         default: s = item_ff.sample_right_outer;
      endcase
      diff = $signed({10'd0, s}) - $signed({9'd0, floor_ff[ch_ff]});
      psum = sel_ff ? (lvl_ff[2] + lvl_ff[1]) : (lvl_ff[3] + lvl_ff[0]);
      pdif = sel_ff ? (lvl_ff[2] - lvl_ff[1]) : (lvl_ff[3] - lvl_ff[0]);
   end

   always_comb begin
      logic [21:0] dabs;
      logic [22:0] pabs;
      dabs = diff[21] ? 22'(-diff) : 22'(diff);
      pabs = pdif[22] ? 23'(-pdif) : 23'(pdif);
      pair_ok = sel_ff ? io_ff : oo_ff;
      if (state_ff == S_DIV_RATIO) begin
         dividend_abs = {3'd0, pabs, 16'd0};
         divisor_abs = psum[22] ? 22'(-psum) : 22'(psum);
         negate = pdif[22] ^ psum[22];
         nbits = 6'd42;
         skip = !pair_ok || (psum == '0);
      end else begin
         dividend_abs = {20'd0, dabs * 22'd100};
         divisor_abs = {6'd0, span_ff[ch_ff]};
         negate = diff[21];
         nbits = 6'd23;
         skip = (span_ff[ch_ff] <= 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         ogain_ff <= 16'sd256;
         igain_ff <= 16'sd256;
         for (int i = 0; i < 4; i++) begin
            tmax_ff[i] <= MaxInit;
            tmin_ff[i] <= MinInit;
            floor_ff[i] <= '0;
         end
         span_ff[0] <= SpanR0;
         span_ff[1] <= SpanR1;
         span_ff[2] <= SpanR1;
         span_ff[3] <= SpanR3;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            if (csr_index == CSR_OUTER_GAIN) ogain_ff <= csr_wdata;
            else igain_ff <= csr_wdata;
         end
         if (state_ff == S_DONE && rsp_free) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  item_ff <= req_data;
                  ch_ff <= 2'd0;
                  sel_ff <= 1'b0;
                  cnt_ff <= '0;
                  rbad_ff <= 1'b0;
                  sbad_ff <= 1'b0;
                  case (action_type'(req_data.action))
                     ACT_CLEAR: for (int i = 0; i < 4; i++) begin
                        tmax_ff[i] <= MaxInit;
                        tmin_ff[i] <= MinInit;
                     end
                     ACT_CAL: for (int i = 0; i < 4; i++) begin
                        if ({1'b0, req_smp[i]} > tmax_ff[i]) tmax_ff[i] <= {1'b0, req_smp[i]};
                        if ({1'b0, req_smp[i]} < tmin_ff[i]) tmin_ff[i] <= {1'b0, req_smp[i]};
                     end
                     ACT_FINISH: for (int i = 0; i < 4; i++) begin
                        floor_ff[i] <= tmin_ff[i];
                        span_ff[i] <= $signed({2'b0, tmax_ff[i], 1'b0}) - $signed({3'b0, tmin_ff[i]});
                     end
                     default: ;
                  endcase
               end
            end
            S_DIV_LVL, S_DIV_RATIO: begin
               if (cnt_ff == '0) begin
                  if (skip) begin
                     if (state_ff == S_DIV_LVL) begin
                        rbad_ff <= 1'b1;
                        lvl_ff[ch_ff] <= '0;
                        ch_ff <= ch_ff + 2'd1;
                     end else begin
                        if (pair_ok) sbad_ff <= 1'b1;
                        if (sel_ff) begin ri_ff <= '0; io_ff <= 1'b0; end
                        else begin ro_ff <= '0; oo_ff <= 1'b0; end
                        sel_ff <= ~sel_ff;
                     end
                  end else begin
                     quo_ff <= dividend_abs << (42 - nbits);
                     rem_ff <= '0;
                     dvs_ff <= divisor_abs;
                     neg_ff <= negate;
                     cnt_ff <= nbits;
                  end
               end else begin
                  if (!trial[22]) rem_ff <= trial[21:0];
                  else rem_ff <= {rem_ff[20:0], quo_ff[41]};
                  quo_ff <= qnext;
                  cnt_ff <= cnt_ff - 6'd1;
                  if (cnt_ff == 6'd1) begin
                     if (state_ff == S_DIV_LVL) begin
                        lvl_ff[ch_ff] <= sat20(qsigned);
                        ch_ff <= ch_ff + 2'd1;
                     end else begin
                        if (sel_ff) ri_ff <= sat24(qsigned);
                        else ro_ff <= sat24(qsigned);
                        sel_ff <= ~sel_ff;
                     end
                  end
               end
               if (state_ff == S_DIV_LVL && state_in == S_DIV_RATIO) begin
                  oo_ff <= (span_ff[0] > 0) && (span_ff[3] > 0);
                  io_ff <= (span_ff[1] > 0) && (span_ff[2] > 0);
                  sel_ff <= 1'b0;
                  acc_ff <= '0;
               end
            end
            S_STEER: begin
               acc_ff <= accsum;
               sel_ff <= ~sel_ff;
            end
            S_DONE: begin
               if (rsp_free) begin
                  if (item_ff.action == ACT_MEASURE) begin
                     res_ff.level_left_outer <= lvl_ff[0];
                     res_ff.level_left_inner <= lvl_ff[1];
                     res_ff.level_right_inner <= lvl_ff[2];
                     res_ff.level_right_outer <= lvl_ff[3];
                     res_ff.outer_ratio <= ro_ff;
                     res_ff.inner_ratio <= ri_ff;
                     res_ff.steer_error <= (oo_ff && io_ff) ? sat24({{8{shifted[33]}}, shifted}) : '0;
                     res_ff.status <= rbad_ff ? ST_RANGE : (sbad_ff ? ST_SUM : ST_OK);
                  end else begin
                     res_ff <= '0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:
            if (req_valid && !req_stall)
               state_in = (req_data.action == ACT_MEASURE) ? S_DIV_LVL : S_DONE;
         S_DIV_LVL:
            if (ch_ff == 2'd3 && ((cnt_ff == 6'd1) || (cnt_ff == '0 && skip)))
               state_in = S_DIV_RATIO;
         S_DIV_RATIO:
            if (sel_ff && ((cnt_ff == 6'd1) || (cnt_ff == '0 && skip)))
               state_in = S_STEER;
         S_STEER:
            if (sel_ff) state_in = S_DONE;
         S_DONE:
            if (rsp_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end
endmodule

### rtl/inr_checker.sv
// port-level checks for the inductor sensor front end, bound to the top level
// depends on inr_pkg and inductor_normalize_diff_ratio_defines.svh
`include "inductor_normalize_diff_ratio_defines.svh"
module inr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input inr_pkg::rsp_type rsp_data
);
   import inr_pkg::*;
   `INR_ASSERT_IMPL(a_out_known, clock, reset, rsp_valid, !$isunknown(rsp_data))
   `INR_ASSERT_NEXT(a_out_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
   `INR_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && !req_stall, req_stall)
   `INR_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid, rsp_data.status <= ST_SUM)
endmodule

bind inductor_normalize_diff_ratio inr_checker u_inr_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

### tb/tb.sv
// testbench for inductor_normalize_diff_ratio: drives calibration and measure items
// with random idling, predicts each result in a scoreboard class and checks it
// depends on inr_pkg and the block's rtl
`timescale 1ns / 1ps
module tb;
   import inr_pkg::*;

   class sensor_scoreboard;
      logic [11:0] trk_max[4];
      logic [12:0] trk_min[4];
      logic [12:0] floor_lvl[4];
      int span_lvl[4];
      int outer_gain, inner_gain;
      rsp_type pending[$];
      int errors;

      function void reset_state();
         int spans[4];
         spans = '{1504, 1158, 1158, 2014};
         for (int i = 0; i < 4; i++) begin
            trk_max[i] = 1000;
            trk_min[i] = 5000;
            floor_lvl[i] = 0;
            span_lvl[i] = spans[i];
         end
         outer_gain = 256;
         inner_gain = 256;
         errors = 0;
      endfunction

      function longint clip(longint v, longint lim);
         if (v > lim) return lim;
         if (v < -lim - 1) return -lim - 1;
         return v;
      endfunction

      function void note_item(req_type r);
         longint s[4], lvl[4], ro, ri, steer, acc, sm;
         bit ok[4], oo, io, range_bad, sum_bad;
         rsp_type e;
         s = '{r.sample_left_outer, r.sample_left_inner, r.sample_right_inner,
               r.sample_right_outer};
         e = '0;
         ro = 0; ri = 0; steer = 0; range_bad = 0; sum_bad = 0;
         case (action_type'(r.action))
            ACT_CLEAR:
               for (int i = 0; i < 4; i++) begin
                  trk_max[i] = 1000;
                  trk_min[i] = 5000;
               end
            ACT_CAL:
               for (int i = 0; i < 4; i++) begin
                  if (s[i] > trk_max[i]) trk_max[i] = 12'(s[i]);
                  if (s[i] < trk_min[i]) trk_min[i] = 13'(s[i]);
               end
            ACT_FINISH:
               for (int i = 0; i < 4; i++) begin
                  floor_lvl[i] = trk_min[i];
                  span_lvl[i] = 2 * int'(trk_max[i]) - int'(trk_min[i]);
               end
            default: begin
               for (int i = 0; i < 4; i++) begin
                  ok[i] = span_lvl[i] > 0;
                  if (ok[i]) lvl[i] = clip(((s[i] - longint'(floor_lvl[i])) * 100)
                                           / span_lvl[i], 524287);
                  else begin
                     lvl[i] = 0;
                     range_bad = 1;
                  end
               end
               oo = ok[0] && ok[3];
               if (oo) begin
                  sm = lvl[3] + lvl[0];
                  if (sm == 0) begin oo = 0; sum_bad = 1; end
                  else ro = clip(((lvl[3] - lvl[0]) * 65536) / sm, 8388607);
               end
               io = ok[1] && ok[2];
               if (io) begin
                  sm = lvl[2] + lvl[1];
                  if (sm == 0) begin io = 0; sum_bad = 1; end
                  else ri = clip(((lvl[2] - lvl[1]) * 65536) / sm, 8388607);
               end
               if (oo && io) begin
                  acc = longint'(outer_gain) * ro + longint'(inner_gain) * ri;
                  steer = clip(acc >>> 8, 8388607);
               end
               e.level_left_outer = 20'(lvl[0]);
               e.level_left_inner = 20'(lvl[1]);
               e.level_right_inner = 20'(lvl[2]);
               e.level_right_outer = 20'(lvl[3]);
               e.outer_ratio = 24'(ro);
               e.inner_ratio = 24'(ri);
               e.steer_error = 24'(steer);
               e.status = range_bad ? ST_RANGE : (sum_bad ? ST_SUM : ST_OK);
            end
         endcase
         pending.push_back(e);
      endfunction

      function void check_result(rsp_type a);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected result %h", $time, a);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (e.level_left_outer !== a.level_left_outer ||
             e.level_left_inner !== a.level_left_inner ||
             e.level_right_inner !== a.level_right_inner ||
             e.level_right_outer !== a.level_right_outer) begin
            $display("%0t levels expected %0d %0d %0d %0d actual %0d %0d %0d %0d", $time,
                     e.level_left_outer, e.level_left_inner, e.level_right_inner,
                     e.level_right_outer, a.level_left_outer, a.level_left_inner,
                     a.level_right_inner, a.level_right_outer);
            errors++;
         end
         if (e.outer_ratio !== a.outer_ratio || e.inner_ratio !== a.inner_ratio) begin
            $display("%0t ratios expected %0d %0d actual %0d %0d", $time, e.outer_ratio,
                     e.inner_ratio, a.outer_ratio, a.inner_ratio);
            errors++;
         end
         if (e.steer_error !== a.steer_error) begin
            $display("%0t steer_error expected %0d actual %0d", $time, e.steer_error,
                     a.steer_error);
            errors++;
         end
         if (e.status !== a.status) begin
            $display("%0t status expected %0d actual %0d", $time, e.status, a.status);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_stall, rsp_valid, rsp_stall = 0;
   logic csr_valid = 0, csr_ready, csr_index = 0;
   logic [15:0] csr_wdata = '0;
   req_type req_data = '0;
   rsp_type rsp_data;
   bit calm = 0;
   int sent = 0;
   sensor_scoreboard sb = new();

   inductor_normalize_diff_ratio uut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   initial begin
      #40_000_000;
      $display("TB_ERROR");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   always @(negedge clock) begin
      rsp_stall <= !reset && !calm && ($urandom_range(99) < 11);
   end

   task automatic send_item(logic [1:0] act, logic [11:0] a, logic [11:0] b,
                            logic [11:0] c, logic [11:0] d);
      req_type r;
      r = '{act, a, b, c, d};
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_data <= r;
      req_valid <= 1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(r);
      sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_gain(logic idx, logic [15:0] val);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_OUTER_GAIN) sb.outer_gain = $signed(val);
      else sb.inner_gain = $signed(val);
      @(negedge clock);
   endtask

   function automatic logic [11:0] rnd_sample();
      case ($urandom_range(5))
         0: return 12'd0;
         1: return 12'hfff;
         default: return 12'($urandom);
      endcase
   endfunction

   task automatic random_item();
      logic [11:0] s[4];
      for (int i = 0; i < 4; i++) s[i] = rnd_sample();
      send_item(2'($urandom_range(3)), s[0], s[1], s[2], s[3]);
   endtask

   task automatic calib_sequence();
      int n;
      logic [11:0] base[4];
      if ($urandom_range(3) != 0)
         send_item(ACT_CLEAR, 12'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
      for (int i = 0; i < 4; i++) base[i] = 12'($urandom_range(4095));
      n = $urandom_range(1, 6);
      repeat (n) send_item(ACT_CAL,
         base[0] ^ 12'($urandom_range(255)), base[1] ^ 12'($urandom_range(255)),
         base[2] ^ 12'($urandom_range(255)), base[3] ^ 12'($urandom_range(255)));
      send_item(ACT_FINISH, 0, 0, 0, 0);
      repeat ($urandom_range(4, 15)) random_measure();
   endtask

   task automatic random_measure();
      send_item(ACT_MEASURE, rnd_sample(), rnd_sample(), rnd_sample(), rnd_sample());
   endtask

   initial begin
      logic [15:0] gains[6];
      sb.reset_state();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // reset spans, extremes
      send_item(ACT_MEASURE, 0, 0, 0, 0);
      send_item(ACT_MEASURE, 12'hfff, 12'hfff, 12'hfff, 12'hfff);
      send_item(ACT_MEASURE, 0, 12'hfff, 0, 12'hfff);
      send_item(ACT_MEASURE, 12'hfff, 0, 12'hfff, 0);
      send_item(ACT_MEASURE, 100, 0, 0, 0);
      // negative span: never calibrated after clear
      send_item(ACT_CLEAR, 12'hfff, 0, 12'hfff, 0);
      send_item(ACT_FINISH, 0, 0, 0, 0);
      send_item(ACT_MEASURE, 1234, 55, 3000, 4095);
      // spans from two calibration samples
      send_item(ACT_CLEAR, 0, 0, 0, 0);
      send_item(ACT_CAL, 2000, 10, 10, 10);
      send_item(ACT_CAL, 4000, 4095, 4095, 4095);
      send_item(ACT_FINISH, 0, 0, 0, 0);
      send_item(ACT_MEASURE, 3000, 10, 10, 10);
      send_item(ACT_MEASURE, 0, 0, 4095, 4095);
      // spans from two further calibration samples
      send_item(ACT_CLEAR, 0, 0, 0, 0);
      send_item(ACT_CAL, 2, 1001, 1001, 2);
      send_item(ACT_CAL, 0, 2000, 2000, 0);
      send_item(ACT_FINISH, 0, 0, 0, 0);
      send_item(ACT_MEASURE, 4095, 4095, 2000, 0);
      send_item(ACT_MEASURE, 0, 0, 0, 0);
      send_item(ACT_MEASURE, 4095, 1, 0, 4095);
      drain();
      gains = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0100, 16'h0001};
      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 6) begin
            write_gain(CSR_OUTER_GAIN, gains[ph]);
            write_gain(CSR_INNER_GAIN, gains[5 - ph]);
         end else begin
            write_gain(CSR_OUTER_GAIN, 16'($urandom));
            write_gain(CSR_INNER_GAIN, 16'($urandom));
         end
         csr_valid <= 0;
         calm = (ph == 3);
         while (sent < (ph + 1) * 210 + 21) begin
            if ($urandom_range(9) < 7) begin
               calib_sequence();
            end else begin
               random_item();
            end
         end
         calm = 0;
         drain();
      end
      if (sb.errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl
rtl/inr_pkg.sv
rtl/inductor_normalize_diff_ratio.sv
rtl/inr_checker.sv
tb/tb.sv
